// File: rtl/assert_macros.svh
// Assertion macros used by the checker file of the project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge outside reset.
`define SWLM_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define SWLM_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// File: rtl/swlm_pkg.sv
// Package with the shared constants and types of the sliding-window median filter.
package swlm_pkg;

   localparam int WINDOW_MAX  = 32;
   localparam int SAMPLE_BITS = 16;
   localparam int CFG_BITS    = 6;
   localparam int COUNT_BITS  = $clog2(WINDOW_MAX + 1);
   localparam int IDX_BITS    = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
   localparam int AGE_BITS    = IDX_BITS;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] value;
      logic [AGE_BITS-1:0]           age;
      logic                          le;
   } cell_view_type;

   typedef struct packed {
      logic                advance;
      logic                full;
      logic [AGE_BITS-1:0] oldest_age;
   } cell_ctl_type;

endpackage

// File: rtl/swlm_cell.sv
// One cell of the sorted window chain: holds one sample and its age.
module swlm_cell
   import swlm_pkg::*;
(
   input  logic                          clock,
   input  cell_ctl_type                  ctl,
   input  logic                          entry_valid,
   input  logic signed [SAMPLE_BITS-1:0] sample,
   input  logic                          shift_in,
   input  cell_view_type                 left_view,
   input  cell_view_type                 right_view,
   output cell_view_type                 own_view,
   output logic                          shift_out
);

   logic signed [SAMPLE_BITS-1:0] value_ff;
   logic signed [SAMPLE_BITS-1:0] value_in;
   logic [AGE_BITS-1:0]           age_ff;
   logic [AGE_BITS-1:0]           age_in;
   logic                          drop_here;
   logic                          shift_here;
   cell_view_type                 cur_view;
   cell_view_type                 prev_view;

   assign own_view.value = value_ff;
   assign own_view.age   = age_ff;
   assign own_view.le    = entry_valid && ($signed(value_ff) <= $signed(sample));

   // When full, the oldest entry leaves; every cell from it upward takes its right neighbor.
   assign drop_here  = ctl.full && entry_valid && (age_ff == ctl.oldest_age);
   assign shift_here = shift_in || drop_here;
   assign shift_out  = shift_here;

   assign cur_view  = shift_here ? right_view : own_view;
   assign prev_view = shift_in ? own_view : left_view;

   always_comb begin
      if (cur_view.le) begin
         value_in = cur_view.value;
         age_in   = cur_view.age + AGE_BITS'(1);
      end else if (prev_view.le) begin
         value_in = sample;
         age_in   = '0;
      end else begin
         value_in = prev_view.value;
         age_in   = prev_view.age + AGE_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.advance) begin
         value_ff <= value_in;
         age_ff   <= age_in;
      end
   end

endmodule

// File: rtl/sliding_window_lower_median.sv
// Top level of the sliding-window lower median filter.
// The req channel carries one signed sample per item; an item is taken at a
// rising edge with req_valid high and req_stall low. The rsp channel returns
// the lower median of the latest k samples, handed over at an edge with
// rsp_valid high and rsp_stall low. The csr channel writes the window size k
// (1 to 32; 0 acts as 1, larger values as 32) and empties the window; it is
// ready only while no result is pending.
// The first k-1 samples after reset or a size write give no result; each
// later sample gives one. A result is registered first in pend_ff and then
// in the rsp output register. A chain of 32 cells updates the sorted window
// as each sample is taken, so one sample is taken every cycle while rsp
// keeps moving. When rsp_stall holds a result, one more result waits inside
// and then req_stall rises until the output drains.
// Synchronous reset sets k to 32, empties the window and drops all results.
module sliding_window_lower_median
   import swlm_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [SAMPLE_BITS-1:0] req_sample,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [SAMPLE_BITS-1:0] rsp_median_value,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [CFG_BITS-1:0]           csr_window_size
);

   logic [CFG_BITS-1:0]           size_ff;
   logic [CFG_BITS-1:0]           size_in;
   logic [COUNT_BITS-1:0]         fill_ff;
   logic [COUNT_BITS-1:0]         fill_in;
   logic                          pend_ff;
   logic                          pend_in;
   logic                          rsp_valid_ff;
   logic                          rsp_valid_in;
   logic signed [SAMPLE_BITS-1:0] rsp_value_ff;
   logic signed [SAMPLE_BITS-1:0] rsp_value_in;
   logic [COUNT_BITS-1:0]         window_k;
   logic [IDX_BITS-1:0]           median_idx;
   logic                          accept;
   logic                          cfg_write;
   logic                          full;
   logic                          result_due;
   logic                          pend_move;
   cell_ctl_type                  ctl;
   cell_view_type                 views [WINDOW_MAX];
   logic                          shift_chain [WINDOW_MAX];

   always_comb begin
      if (size_ff == '0) begin
         window_k = COUNT_BITS'(1);
      end else if (size_ff > CFG_BITS'(WINDOW_MAX)) begin
         window_k = COUNT_BITS'(WINDOW_MAX);
      end else begin
         window_k = COUNT_BITS'(size_ff);
      end
   end

   assign median_idx = IDX_BITS'((window_k - COUNT_BITS'(1)) >> 1);
   assign full       = (fill_ff == window_k);
   assign accept     = req_valid && !req_stall;
   assign cfg_write  = csr_valid && csr_ready;
   assign result_due = accept && (full || ((fill_ff + COUNT_BITS'(1)) == window_k));
   assign pend_move  = pend_ff && (!rsp_valid_ff || !rsp_stall);

   assign req_stall = pend_ff && !pend_move;
   assign csr_ready = !pend_ff && !rsp_valid_ff;

   assign ctl.advance    = accept;
   assign ctl.full       = full;
   assign ctl.oldest_age = AGE_BITS'(window_k - COUNT_BITS'(1));

   assign shift_chain[0] = 1'b0;

   for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
      logic          entry_valid;
      cell_view_type left_view;
      cell_view_type right_view;

      assign entry_valid = (COUNT_BITS'(i) < fill_ff);

      if (i == 0) begin : g_first
         assign left_view = '{value: '0, age: '0, le: 1'b1};
      end else begin : g_inner_left
         assign left_view = views[i-1];
      end

      if (i == WINDOW_MAX - 1) begin : g_last
         assign right_view = '{value: '0, age: '0, le: 1'b0};
         swlm_cell u_cell (
            .clock       (clock),
            .ctl         (ctl),
            .entry_valid (entry_valid),
            .sample      (req_sample),
            .shift_in    (shift_chain[i]),
            .left_view   (left_view),
            .right_view  (right_view),
            .own_view    (views[i]),
            .shift_out   ()
         );
      end else begin : g_inner_right
         assign right_view = views[i+1];
         swlm_cell u_cell (
            .clock       (clock),
            .ctl         (ctl),
            .entry_valid (entry_valid),
            .sample      (req_sample),
            .shift_in    (shift_chain[i]),
            .left_view   (left_view),
            .right_view  (right_view),
            .own_view    (views[i]),
            .shift_out   (shift_chain[i+1])
         );
      end
   end

   always_comb begin
      size_in = size_ff;
      fill_in = fill_ff;
      if (cfg_write) begin
         size_in = csr_window_size;
         fill_in = '0;
      end else if (accept && !full) begin
         fill_in = fill_ff + COUNT_BITS'(1);
      end
   end

   always_comb begin
      pend_in      = result_due || (pend_ff && !pend_move);
      rsp_valid_in = pend_move || (rsp_valid_ff && rsp_stall);
      rsp_value_in = pend_move ? views[median_idx].value : rsp_value_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff      <= CFG_BITS'(WINDOW_MAX);
         fill_ff      <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         size_ff      <= size_in;
         fill_ff      <= fill_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_value_ff <= rsp_value_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_median_value = rsp_value_ff;

endmodule

// File: rtl/swlm_checker.sv
// Port checker of the sliding-window median filter and its bind to the top level.
`include "assert_macros.svh"

module swlm_checker
   import swlm_pkg::*;
(
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_stall,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic signed [SAMPLE_BITS-1:0] rsp_median_value,
   input logic                          csr_valid,
   input logic                          csr_ready
);

   `SWLM_ASSERT(a_rsp_hold, rsp_valid && rsp_stall |=> rsp_valid, "stalled rsp item dropped")
   `SWLM_ASSERT(a_rsp_stable, rsp_valid && rsp_stall |=> $stable(rsp_median_value),
                "stalled rsp item changed")
   `SWLM_ASSERT(a_rsp_cause, $rose(rsp_valid) |-> $past(req_valid && !req_stall, 2),
                "rsp item without a req item two cycles before")
   `SWLM_ASSERT(a_csr_idle, csr_valid && csr_ready |-> !rsp_valid,
                "window size written while a result waits")
   `SWLM_ASSERT_ALWAYS(a_reset_clear, reset |=> !rsp_valid, "rsp item present after reset")

endmodule

bind sliding_window_lower_median swlm_checker u_swlm_checker (.*);

// File: tb/sv/sliding_window_lower_median_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the sliding-window lower median filter.
module sliding_window_lower_median_tb
   import swlm_pkg::*;
();

   logic                          clock = 1'b0;
   logic                          reset;
   logic                          req_valid;
   logic                          req_stall;
   logic signed [SAMPLE_BITS-1:0] req_sample;
   logic                          rsp_valid;
   logic                          rsp_stall;
   logic signed [SAMPLE_BITS-1:0] rsp_median_value;
   logic                          csr_valid;
   logic                          csr_ready;
   logic [CFG_BITS-1:0]           csr_window_size;

   int unsigned                   window_len = WINDOW_MAX;
   logic signed [SAMPLE_BITS-1:0] recent_samples[$];
   logic signed [SAMPLE_BITS-1:0] expected_medians[$];

   bit req_idle_on = 1'b1;
   bit rsp_idle_on = 1'b1;
   int long_hold_cycles = 0;
   int error_count = 0;
   int samples_sent = 0;
   int medians_checked = 0;
   int size_writes = 0;

   sliding_window_lower_median dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_sample       (req_sample),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_median_value (rsp_median_value),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_window_size  (csr_window_size)
   );

   always #10 clock = ~clock;

   // The window is kept in arrival order; the median is found by counting ranks.
   function automatic void take_sample(input logic signed [SAMPLE_BITS-1:0] value);
      int unsigned rank;
      int below;
      int not_above;
      logic signed [SAMPLE_BITS-1:0] median;
      while (recent_samples.size() >= window_len) begin
         void'(recent_samples.pop_front());
      end
      recent_samples = {recent_samples, value};
      if (recent_samples.size() == window_len) begin
         rank = (window_len - 1) / 2;
         median = recent_samples[0];
         foreach (recent_samples[i]) begin
            below = 0;
            not_above = 0;
            foreach (recent_samples[j]) begin
               if (recent_samples[j] < recent_samples[i]) below++;
               if (recent_samples[j] <= recent_samples[i]) not_above++;
            end
            if (below <= int'(rank) && int'(rank) < not_above) median = recent_samples[i];
         end
         expected_medians = {expected_medians, median};
      end
   endfunction

   function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
      logic signed [SAMPLE_BITS-1:0] value;
      case ($urandom_range(0, 9))
         0: begin
            case ($urandom_range(0, 3))
               0: value = 16'sh8000;
               1: value = 16'sh7fff;
               2: value = 16'sh0000;
               default: value = 16'shffff;
            endcase
         end
         1, 2: value = $signed(16'($urandom_range(0, 8))) - 16'sd4;
         default: value = 16'($urandom);
      endcase
      return value;
   endfunction

   task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] value);
      int gap;
      gap = req_idle_on ? $urandom_range(0, 14) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_sample <= value;
      do @(posedge clock); while (req_stall);
      take_sample(value);
      samples_sent++;
   endtask

   task automatic settle_window();
      req_valid <= 1'b0;
      while (expected_medians.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_window_size(input logic [CFG_BITS-1:0] size);
      settle_window();
      csr_valid <= 1'b1;
      csr_window_size <= size;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      window_len = (size == 0) ? 1 : (size > WINDOW_MAX) ? WINDOW_MAX : size;
      recent_samples.delete();
      size_writes++;
   endtask

   task automatic test_reset_window();
      repeat (70) send_sample(pick_sample());
   endtask

   task automatic test_directed_extremes();
      logic signed [SAMPLE_BITS-1:0] pairs[] = '{16'sd5, -16'sd5, 16'sh7fff, 16'sh8000,
                                                 16'sd7, 16'sd7, 16'sd7};
      logic signed [SAMPLE_BITS-1:0] triples[] = '{16'sd4, 16'sd4, -16'sd2, 16'sd4, 16'sh8000,
                                                   16'sh7fff, 16'sh7fff, 16'sd0};
      write_window_size(6'd0);
      send_sample(16'sh8000);
      send_sample(16'sh7fff);
      send_sample(16'sh0000);
      send_sample(16'shffff);
      write_window_size(6'd2);
      foreach (pairs[i]) send_sample(pairs[i]);
      write_window_size(6'd3);
      foreach (triples[i]) send_sample(triples[i]);
   endtask

   task automatic test_window_sizes();
      logic [CFG_BITS-1:0] sizes[] = '{6'd1, 6'd2, 6'd3, 6'd4, 6'd5, 6'd6, 6'd7, 6'd8, 6'd9,
                                       6'd15, 6'd16, 6'd17, 6'd31, 6'd32, 6'd33, 6'd63};
      int count;
      for (int i = 0; i < sizes.size() + 3; i++) begin
         req_idle_on = ($urandom_range(0, 3) != 0);
         rsp_idle_on = ($urandom_range(0, 3) != 0);
         if (i < sizes.size()) write_window_size(sizes[i]);
         else write_window_size(6'($urandom_range(1, 63)));
         count = 30 + 2 * window_len;
         repeat (count) send_sample(pick_sample());
      end
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
   endtask

   task automatic test_output_backpressure();
      write_window_size(6'd4);
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      long_hold_cycles = 120;
      repeat (60) send_sample(pick_sample());
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
   endtask

   task automatic test_full_rate();
      write_window_size(6'd5);
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      repeat (100) send_sample(pick_sample());
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
   endtask

   initial begin
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_sample <= '0;
      csr_valid <= 1'b0;
      csr_window_size <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_window();
      test_directed_extremes();
      test_window_sizes();
      test_output_backpressure();
      test_full_rate();
      settle_window();
      repeat (10) @(posedge clock);
      while (expected_medians.size() != 0) begin
         error_count++;
         $display("%0t: missing median: expected %0d, actual none", $time,
                  expected_medians.pop_front());
      end
      $display("Sent %0d samples and checked %0d medians over %0d window size writes,",
               samples_sent, medians_checked, size_writes);
      $display("including sizes 0, 1, 32 and above, random idling and a long output stall.");
      if (error_count == 0) begin
         $display("sliding_window_lower_median regression: pass");
      end else begin
         $display("sliding_window_lower_median regression: fail");
      end
      $finish;
   end

   initial begin
      int hold;
      rsp_stall <= 1'b0;
      @(negedge reset);
      forever begin
         hold = rsp_idle_on ? $urandom_range(0, 14) : 0;
         if (long_hold_cycles > 0) begin
            hold = long_hold_cycles;
            long_hold_cycles = 0;
         end
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_medians.size() == 0) begin
            error_count++;
            $display("%0t: unexpected median: expected none, actual %0d", $time,
                     rsp_median_value);
         end else begin
            if (rsp_median_value !== expected_medians[0]) begin
               error_count++;
               $display("%0t: median_value mismatch: expected %0d, actual %0d", $time,
                        expected_medians[0], rsp_median_value);
            end
            void'(expected_medians.pop_front());
            medians_checked++;
         end
      end
   end

   initial begin
      #8_000_000;
      $display("Timeout with %0d medians still outstanding.", expected_medians.size());
      $display("sliding_window_lower_median regression: fail");
      $finish;
   end

endmodule

// File: files.f
+incdir+rtl
rtl/swlm_pkg.sv
rtl/swlm_cell.sv
rtl/sliding_window_lower_median.sv
rtl/swlm_checker.sv
tb/sv/sliding_window_lower_median_tb.sv
